/* sv/page_bitmap_allocator_defines.svh */
// Assertion macros for the page bitmap allocator.
// Depends on nothing; taken in by the modules that carry checks.
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page allocator sequence check failed");

`endif

/* sv/pba_pkg.sv */
// Shared types and constants for the page bitmap allocator.
// No dependencies.
package pba_pkg;

   localparam int POOL_PAGES_DEF = 4096;
   localparam int PAGE_SHIFT_DEF = 12;
   localparam int WORD_BITS      = 32;
   localparam int WORD_SHIFT     = 5;

   localparam logic [31:0] KERNEL_BASE_RST  = 32'h0020_0000;
   localparam logic [31:0] USER_BASE_RST    = 32'h0120_0000;
   localparam logic [12:0] KERNEL_PAGES_RST = 13'd4096;
   localparam logic [12:0] USER_PAGES_RST   = 13'd4096;

   localparam logic [1:0] REG_KERNEL_BASE  = 2'd0;
   localparam logic [1:0] REG_USER_BASE    = 2'd1;
   localparam logic [1:0] REG_KERNEL_PAGES = 2'd2;
   localparam logic [1:0] REG_USER_PAGES   = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD      = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] hit_bit;
      logic       any_used;
      logic [4:0] last_used;
   } scan_type;

endpackage

/* sv/pba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pba_word_scan.sv */
// Evaluates one 32-page bitmap word against a running free-run length.
// Depends on pba_pkg.
module pba_word_scan #(
   parameter int XW = 16
) (
   input  logic [31:0]       used,
   input  logic [XW-1:0]     run_in,
   input  logic [XW-1:0]     count,
   output pba_pkg::scan_type res
);

   always_comb begin
      logic          seen;
      logic [4:0]    last;
      logic [XW-1:0] run_j;
      res   = '0;
      seen  = 1'b0;
      last  = '0;
      run_j = '0;
      for (int j = 0; j < pba_pkg::WORD_BITS; j++) begin
         if (used[j]) begin
            seen = 1'b1;
            last = 5'(j);
         end else begin
            // length of the free run ending at this page
            if (seen) begin
               run_j = XW'(j) - XW'(last);
            end else begin
               run_j = run_in + XW'(j) + XW'(1);
            end
            if (!res.hit && run_j >= count) begin
               res.hit     = 1'b1;
               res.hit_bit = 5'(j);
            end
         end
      end
      res.any_used  = seen;
      res.last_used = last;
   end

endmodule

/* sv/page_bitmap_allocator.sv */
// Top level of the two-pool first-fit page allocator.
// Depends on pba_pkg, pba_ram, pba_word_scan and page_bitmap_allocator_defines.svh.
//
// Use: one request transaction (req_*) gives an action, pool, page count and,
// for a free, an address. One response transaction (rsp_*) returns a status
// and, for a successful allocation, the run's start address. Requests are
// handled one at a time; req_ready is high only while the block is idle.
// Both bitmaps live in one RAM of 32-bit words, the pool selecting the upper
// half. An allocation scans one word per cycle through the RAM read port
// to find a run, then marks each word of the run in turn (read, modify,
// write). A free clears each word it touches by the same read, modify, write.
// After reset the RAM is swept to zero, one row a cycle, over 2*128 rows at
// the default size; no request is taken meanwhile, CSR writes still are.
// A response is held in its register until rsp_ready; a stalled receiver
// holds the block, which takes the next request once the response is taken.
// CSR writes land immediately and must only be made while idle.
`include "page_bitmap_allocator_defines.svh"

module page_bitmap_allocator #(
   parameter int POOL_PAGES = pba_pkg::POOL_PAGES_DEF,
   parameter int PAGE_SHIFT = pba_pkg::PAGE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic        req_pool,
   input  logic [12:0] req_count,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_start_address,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int WORDS = (POOL_PAGES + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int AW    = WA_W + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int GW    = WA_W + pba_pkg::WORD_SHIFT;
   localparam int PW    = $clog2(POOL_PAGES + 1);
   localparam int LW    = (PW > 13) ? PW : 13;
   localparam int XW    = ((GW > LW) ? GW : LW) + 1;
   localparam logic [31:0] PAGE_MASK = ~((32'd1 << PAGE_SHIFT) - 32'd1);

   // configuration registers
   logic [31:0] kernel_base_ff, user_base_ff;
   logic [12:0] kernel_pages_ff, user_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_base_ff  <= pba_pkg::KERNEL_BASE_RST;
         user_base_ff    <= pba_pkg::USER_BASE_RST;
         kernel_pages_ff <= pba_pkg::KERNEL_PAGES_RST;
         user_pages_ff   <= pba_pkg::USER_PAGES_RST;
      end else if (csr_we) begin
         case (csr_index)
            pba_pkg::REG_KERNEL_BASE:  kernel_base_ff  <= csr_wdata;
            pba_pkg::REG_USER_BASE:    user_base_ff    <= csr_wdata;
            pba_pkg::REG_KERNEL_PAGES: kernel_pages_ff <= csr_wdata[12:0];
            pba_pkg::REG_USER_PAGES:   user_pages_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // control and working registers
   pba_pkg::state_type state_ff, state_in;
   logic          act_ff, act_in;
   logic          pool_ff, pool_in;
   logic [XW-1:0] count_ff, count_in;
   logic [31:0]   addr_ff, addr_in;
   logic [XW-1:0] first_ff, first_in;
   logic [XW-1:0] last_ff, last_in;
   logic [WA_W-1:0] lastw_ff, lastw_in;
   logic [XW-1:0] run_ff, run_in;
   logic [WA_W-1:0] ra_ff, ra_in;
   logic [WA_W-1:0] pa_ff, pa_in;
   logic          pv_ff, pv_in;
   logic [WA_W-1:0] mw_ff, mw_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   start_ff, start_in;
   logic [XW-1:0] pages_ff, pages_in;
   logic [31:0]   base_ff, base_in;

   // RAM port signals
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   pba_ram #(
      .WIDTH (pba_pkg::WORD_BITS),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // decode helpers
   logic [31:0]   kb, ub;
   logic          free_user, sel_pool;
   logic [XW-1:0] pages_sel;
   logic [31:0]   base_sel, offset, idx32, pages32;
   logic          free_bad;

   function automatic logic [XW-1:0] eff_pages(input logic [12:0] reg_val);
      logic [LW-1:0] r;
      r = LW'(reg_val);
      return (r > LW'(POOL_PAGES)) ? XW'(POOL_PAGES) : XW'(r);
   endfunction

   always_comb begin
      kb        = kernel_base_ff & PAGE_MASK;
      ub        = user_base_ff & PAGE_MASK;
      free_user = addr_ff >= ub;
      sel_pool  = (act_ff == pba_pkg::ACT_FREE) ? free_user : pool_ff;
      pages_sel = sel_pool ? eff_pages(user_pages_ff) : eff_pages(kernel_pages_ff);
      base_sel  = sel_pool ? ub : kb;
      offset    = addr_ff - base_sel;
      idx32     = offset >> PAGE_SHIFT;
      pages32   = 32'(pages_sel);
      free_bad  = (count_ff == '0) || (addr_ff < base_sel) || (idx32 >= pages32)
                  || (32'(count_ff) > pages32 - idx32);
   end

   // scan of the word returned by the RAM
   logic [31:0]       used_word;
   pba_pkg::scan_type scan_res;
   logic [XW-1:0]     hit_end;

   always_comb begin
      for (int j = 0; j < pba_pkg::WORD_BITS; j++) begin
         // pages past the pool's end count as used
         used_word[j] = rd_data[j] | (XW'({pa_ff, 5'(j)}) >= pages_ff);
      end
   end

   pba_word_scan #(.XW(XW)) u_scan (
      .used   (used_word),
      .run_in (run_ff),
      .count  (count_ff),
      .res    (scan_res)
   );

   assign hit_end = XW'({pa_ff, scan_res.hit_bit});

   // run mask of the word being marked or cleared
   logic [31:0] run_mask;

   always_comb begin
      for (int j = 0; j < pba_pkg::WORD_BITS; j++) begin
         run_mask[j] = (XW'({mw_ff, 5'(j)}) >= first_ff)
                       && (XW'({mw_ff, 5'(j)}) <= last_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      pool_in   = pool_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      lastw_in  = lastw_ff;
      run_in    = run_ff;
      ra_in     = ra_ff;
      pa_in     = pa_ff;
      pv_in     = pv_ff;
      mw_in     = mw_ff;
      clr_in    = clr_ff;
      status_in = status_ff;
      start_in  = start_ff;
      pages_in  = pages_ff;
      base_in   = base_ff;
      wr_en     = 1'b0;
      wr_addr   = {pool_ff, mw_ff};
      wr_data   = '0;
      rd_addr   = {pool_ff, mw_ff};
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      case (state_ff)
         pba_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end

         pba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in   = req_action;
               pool_in  = req_pool;
               count_in = XW'(req_count);
               addr_in  = req_address;
               state_in = pba_pkg::ST_DECODE;
            end
         end

         pba_pkg::ST_DECODE: begin
            pool_in  = sel_pool;
            pages_in = pages_sel;
            base_in  = base_sel;
            start_in = '0;
            if (act_ff == pba_pkg::ACT_FREE) begin
               if (free_bad) begin
                  status_in = pba_pkg::STATUS_BAD;
                  state_in  = pba_pkg::ST_RESP;
               end else begin
                  first_in = XW'(idx32);
                  last_in  = XW'(idx32) + count_ff - XW'(1);
                  mw_in    = WA_W'(XW'(idx32) >> pba_pkg::WORD_SHIFT);
                  lastw_in = WA_W'((XW'(idx32) + count_ff - XW'(1)) >> pba_pkg::WORD_SHIFT);
                  state_in = pba_pkg::ST_MARK_RD;
               end
            end else if (count_ff == '0) begin
               status_in = pba_pkg::STATUS_BAD;
               state_in  = pba_pkg::ST_RESP;
            end else if (pages_sel == '0) begin
               status_in = pba_pkg::STATUS_NO_SPACE;
               state_in  = pba_pkg::ST_RESP;
            end else begin
               lastw_in = WA_W'((pages_sel - XW'(1)) >> pba_pkg::WORD_SHIFT);
               ra_in    = '0;
               pv_in    = 1'b0;
               run_in   = '0;
               state_in = pba_pkg::ST_SCAN;
            end
         end

         pba_pkg::ST_SCAN: begin
            // issue the next word while evaluating the one just returned
            rd_addr = {pool_ff, ra_ff};
            ra_in   = ra_ff + WA_W'(1);
            pa_in   = ra_ff;
            pv_in   = 1'b1;
            if (pv_ff) begin
               if (scan_res.hit) begin
                  first_in = hit_end + XW'(1) - count_ff;
                  last_in  = hit_end;
                  mw_in    = WA_W'((hit_end + XW'(1) - count_ff) >> pba_pkg::WORD_SHIFT);
                  lastw_in = pa_ff;
                  state_in = pba_pkg::ST_MARK_RD;
               end else if (pa_ff == lastw_ff) begin
                  status_in = pba_pkg::STATUS_NO_SPACE;
                  state_in  = pba_pkg::ST_RESP;
               end else begin
                  run_in = scan_res.any_used ? XW'(5'd31 - scan_res.last_used)
                                             : run_ff + XW'(pba_pkg::WORD_BITS);
               end
            end
         end

         pba_pkg::ST_MARK_RD: begin
            state_in = pba_pkg::ST_MARK_WR;
         end

         pba_pkg::ST_MARK_WR: begin
            wr_en   = 1'b1;
            wr_data = (act_ff == pba_pkg::ACT_FREE) ? (rd_data & ~run_mask)
                                                    : (rd_data | run_mask);
            if (mw_ff == lastw_ff) begin
               status_in = pba_pkg::STATUS_OK;
               start_in  = (act_ff == pba_pkg::ACT_FREE) ? 32'd0
                           : (32'(first_ff) << PAGE_SHIFT) + base_ff;
               state_in  = pba_pkg::ST_RESP;
            end else begin
               mw_in    = mw_ff + WA_W'(1);
               state_in = pba_pkg::ST_MARK_RD;
            end
         end

         pba_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end

         default: state_in = pba_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pba_pkg::ST_CLEAR;
         clr_ff   <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pv_ff    <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      pool_ff   <= pool_in;
      count_ff  <= count_in;
      addr_ff   <= addr_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      lastw_ff  <= lastw_in;
      run_ff    <= run_in;
      ra_ff     <= ra_in;
      pa_ff     <= pa_in;
      mw_ff     <= mw_in;
      status_ff <= status_in;
      start_ff  <= start_in;
      pages_ff  <= pages_in;
      base_ff   <= base_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_start_address = start_ff;

   // checks
   `PBA_ASSERT_IMP(a_one_at_a_time, clock, reset, req_ready, !rsp_valid)
   `PBA_ASSERT_IMP(a_status_code, clock, reset, rsp_valid,
      rsp_status == pba_pkg::STATUS_OK || rsp_status == pba_pkg::STATUS_NO_SPACE ||
      rsp_status == pba_pkg::STATUS_BAD)
   `PBA_ASSERT_IMP(a_zero_addr_on_fail, clock, reset,
      rsp_valid && rsp_status != pba_pkg::STATUS_OK, rsp_start_address == 32'd0)
   `PBA_ASSERT_IMP(a_write_phase, clock, reset, wr_en,
      state_ff == pba_pkg::ST_CLEAR || state_ff == pba_pkg::ST_MARK_WR)
   `PBA_ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && req_ready,
      state_ff == pba_pkg::ST_DECODE)

endmodule
